// File: design/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants of the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

   localparam int DEBOUNCE_WIDTH = 8;
   localparam int LONG_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int REQ_DATA_WIDTH  = 8;
   localparam int RSP_DATA_WIDTH  = 8;

   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = 8'd10;
   localparam logic [LONG_WIDTH-1:0]     LONG_PRESS_RESET = 16'd600;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_TICKS   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS_TICKS = 2'd1;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_SHORT = 2'd1,
      EV_LONG  = 2'd2
   } press_event_type;

   typedef struct packed {
      logic raw_pressed;
      logic tick;
   } poll_type;

   typedef struct packed {
      logic pressed;
      logic tick;
   } level_type;

endpackage

// File: design/button_debounce_press_classifier_top.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_top
// Debounces polls of an active-low button and classifies short and long presses.
// ----------------------------------------------------------------------------
// Each request on the req_ channel is one poll of the button pin with a flag
// that marks whether a millisecond tick passed since the previous poll. Every
// request yields exactly one response on the rsp_ channel with the press event
// and the debounced button state after that poll.
// A request is captured in an input register, processed in one pass of logic
// that also updates the debounce and hold state, and lands in a response
// register. One request is taken every cycle when the receiver keeps up.
// When the receiver stalls, the response register holds its data and the
// input register still takes one more request; after that req_tready drops
// until the response is taken. No request is ever lost or repeated.
// Reset clears the debounce and hold state, empties both registers and
// restores the settings to a debounce of 10 ticks and a long press of 600
// ticks. The user must write the settings through the csr_ port only while
// no request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_top import bdpc_pkg::*; #(
   parameter int TIME_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_DATA_WIDTH-1:0]  req_tdata,   // button_level, tick
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,   // press_event[1:0], debounced_pressed
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic                      in_valid_ff;
   poll_type                  in_poll_ff;
   logic                      out_valid_ff;
   press_event_type           out_event_ff;
   logic                      out_pressed_ff;
   logic [DEBOUNCE_WIDTH-1:0] debounce_ticks_ff;
   logic [LONG_WIDTH-1:0]     long_press_ticks_ff;
   logic                      advance;
   level_type                 level;
   press_event_type           press_event;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff   <= DEBOUNCE_RESET;
         long_press_ticks_ff <= LONG_PRESS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE_TICKS:   debounce_ticks_ff   <= csr_wdata[DEBOUNCE_WIDTH-1:0];
            CSR_LONG_PRESS_TICKS: long_press_ticks_ff <= csr_wdata[LONG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_poll_ff.raw_pressed <= ~req_tdata[0];
         in_poll_ff.tick        <= req_tdata[1];
      end
   end

   bdpc_debounce #(
      .TIME_WIDTH(TIME_WIDTH)
   ) u_debounce (
      .clock          (clock),
      .reset          (reset),
      .enable         (advance),
      .poll           (in_poll_ff),
      .debounce_ticks (debounce_ticks_ff),
      .level          (level)
   );

   bdpc_classify #(
      .TIME_WIDTH(TIME_WIDTH)
   ) u_classify (
      .clock            (clock),
      .reset            (reset),
      .enable           (advance),
      .level            (level),
      .long_press_ticks (long_press_ticks_ff),
      .press_event      (press_event)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_event_ff   <= press_event;
         out_pressed_ff <= level.pressed;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH-3){1'b0}}, out_pressed_ff, out_event_ff};

endmodule

// File: design/bdpc_debounce.sv
// ----------------------------------------------------------------------------
// bdpc_debounce
// Stability age counter that adopts the raw level once it has held long enough.
// ----------------------------------------------------------------------------
module bdpc_debounce import bdpc_pkg::*; #(
   parameter int TIME_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  poll_type                  poll,
   input  logic [DEBOUNCE_WIDTH-1:0] debounce_ticks,
   output level_type                 level
);

   logic                  last_raw_ff;
   logic                  last_raw_in;
   logic [TIME_WIDTH-1:0] stable_age_ff;
   logic [TIME_WIDTH-1:0] stable_age_in;
   logic                  debounced_ff;
   logic                  debounced_in;

   always_comb begin
      last_raw_in   = last_raw_ff;
      stable_age_in = stable_age_ff;
      if (poll.raw_pressed != last_raw_ff) begin
         last_raw_in   = poll.raw_pressed;
         stable_age_in = '0;
      end else if (poll.tick && (stable_age_ff != '1)) begin
         stable_age_in = stable_age_ff + TIME_WIDTH'(1);
      end
      if (stable_age_in >= TIME_WIDTH'(debounce_ticks)) begin
         debounced_in = poll.raw_pressed;
      end else begin
         debounced_in = debounced_ff;
      end
   end

   assign level.pressed = debounced_in;
   assign level.tick    = poll.tick;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff   <= 1'b0;
         stable_age_ff <= '0;
         debounced_ff  <= 1'b0;
      end else if (enable) begin
         last_raw_ff   <= last_raw_in;
         stable_age_ff <= stable_age_in;
         debounced_ff  <= debounced_in;
      end
   end

endmodule

// File: design/bdpc_classify.sv
// ----------------------------------------------------------------------------
// bdpc_classify
// Hold timer that reports a long press once and a short press on release.
// ----------------------------------------------------------------------------
module bdpc_classify import bdpc_pkg::*; #(
   parameter int TIME_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  level_type             level,
   input  logic [LONG_WIDTH-1:0] long_press_ticks,
   output press_event_type       press_event
);

   localparam int CMP_WIDTH = (TIME_WIDTH > LONG_WIDTH) ? TIME_WIDTH : LONG_WIDTH;

   logic                  previous_ff;
   logic                  previous_in;
   logic [TIME_WIDTH-1:0] hold_time_ff;
   logic [TIME_WIDTH-1:0] hold_time_in;
   logic                  long_reported_ff;
   logic                  long_reported_in;

   always_comb begin
      previous_in      = previous_ff;
      hold_time_in     = hold_time_ff;
      long_reported_in = long_reported_ff;
      press_event      = EV_NONE;
      if (level.pressed && !previous_ff) begin
         previous_in      = 1'b1;
         hold_time_in     = '0;
         long_reported_in = 1'b0;
      end else if (level.pressed && level.tick && (hold_time_ff != '1)) begin
         hold_time_in = hold_time_ff + TIME_WIDTH'(1);
      end
      if (level.pressed) begin
         if ((CMP_WIDTH'(hold_time_in) >= CMP_WIDTH'(long_press_ticks)) &&
             !long_reported_in) begin
            press_event      = EV_LONG;
            long_reported_in = 1'b1;
         end
      end else if (previous_ff) begin
         previous_in      = 1'b0;
         long_reported_in = 1'b0;
         if (!long_reported_ff) begin
            press_event = EV_SHORT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_ff      <= 1'b0;
         hold_time_ff     <= '0;
         long_reported_ff <= 1'b0;
      end else if (enable) begin
         previous_ff      <= previous_in;
         hold_time_ff     <= hold_time_in;
         long_reported_ff <= long_reported_in;
      end
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the button debounce and press classifier.
// ----------------------------------------------------------------------------
// Polls of the button pin are queued by the stimulus process and sent in
// bursts. Every accepted request is run through a cycle-free model of the
// debounce and hold logic, and the response it should produce is queued.
// Responses are taken under a random stall pattern and compared in order.
// The run steps through several debounce and long-press settings, including
// the extremes of the debounce setting and a zero long-press setting.
// ----------------------------------------------------------------------------
module testbench import bdpc_pkg::*;;

   localparam int  TIME_W      = 16;
   localparam logic [TIME_W-1:0] TIME_SAT = {TIME_W{1'b1}};
   localparam int  CYCLE_LIMIT = 4000000;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HIGH = 2'd3;

   typedef struct packed {
      logic tick;
      logic level;
   } pin_poll_type;

   typedef struct {
      press_event_type  ev;
      logic             pressed;
   } press_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_DATA_WIDTH-1:0]  req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]  rsp_tdata;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   pin_poll_type     pending_polls[$];
   press_result_type expected_results[$];
   int               polls_queued = 0;
   int               responses_seen = 0;
   int               err_count = 0;
   int               cycle_count = 0;
   logic             req_taken = 1'b0;

   // Model state and settings.
   logic [DEBOUNCE_WIDTH-1:0] cfg_debounce;
   logic [LONG_WIDTH-1:0]     cfg_long;
   logic                      raw_was_pressed;
   logic [TIME_W-1:0]         age_ticks;
   logic                      level_debounced;
   logic                      level_prev;
   logic [TIME_W-1:0]         held_ticks;
   logic                      long_sent;

   button_debounce_press_classifier_top #(.TIME_WIDTH(TIME_W)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic press_result_type classify_poll(input pin_poll_type p);
      press_result_type r;
      logic             raw_pressed;
      raw_pressed = ~p.level;
      r.ev = EV_NONE;
      if (raw_pressed != raw_was_pressed) begin
         raw_was_pressed = raw_pressed;
         age_ticks = '0;
      end else if (p.tick && age_ticks != TIME_SAT) begin
         age_ticks = age_ticks + 1'b1;
      end
      if (age_ticks >= cfg_debounce) level_debounced = raw_pressed;

      if (level_debounced && !level_prev) begin
         level_prev = 1'b1;
         held_ticks = '0;
         long_sent = 1'b0;
      end else if (level_debounced && level_prev && p.tick && held_ticks != TIME_SAT) begin
         held_ticks = held_ticks + 1'b1;
      end

      if (level_debounced) begin
         if (held_ticks >= cfg_long && !long_sent) begin
            r.ev = EV_LONG;
            long_sent = 1'b1;
         end
      end else if (level_prev) begin
         level_prev = 1'b0;
         if (long_sent) long_sent = 1'b0;
         else r.ev = EV_SHORT;
      end
      r.pressed = level_debounced;
      return r;
   endfunction

   // Model update, expectation store and response checking.
   always @(posedge clock) begin
      press_result_type got;
      press_result_type want;
      if (reset) begin
         cfg_debounce    = DEBOUNCE_RESET;
         cfg_long        = LONG_PRESS_RESET;
         raw_was_pressed = 1'b0;
         age_ticks       = '0;
         level_debounced = 1'b0;
         level_prev      = 1'b0;
         held_ticks      = '0;
         long_sent       = 1'b0;
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (csr_we) begin
            case (csr_index)
               CSR_DEBOUNCE_TICKS:   cfg_debounce = csr_wdata[DEBOUNCE_WIDTH-1:0];
               CSR_LONG_PRESS_TICKS: cfg_long = csr_wdata[LONG_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(classify_poll(pin_poll_type'(req_tdata[1:0])));
         if (rsp_tvalid && rsp_tready) begin
            responses_seen++;
            got.ev = press_event_type'(rsp_tdata[1:0]);
            got.pressed = rsp_tdata[2];
            if (expected_results.size() == 0) begin
               $error("unexpected response: press_event %0d debounced_pressed %0d",
                      got.ev, got.pressed);
               err_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.ev != want.ev) begin
                  $error("press_event: expected %0d, actual %0d", want.ev, got.ev);
                  err_count++;
               end
               if (got.pressed != want.pressed) begin
                  $error("debounced_pressed: expected %0d, actual %0d",
                         want.pressed, got.pressed);
                  err_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Request driver: bursts of random length separated by random gaps.
   int burst_left = 1;
   int gap_left = 0;
   always @(negedge clock) begin
      pin_poll_type p;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_polls.size() > 0) begin
            p = pending_polls.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {{(REQ_DATA_WIDTH-2){1'b0}}, p};
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response receiver: its own run / random / stall pattern plus one long hold-off.
   int rx_mode = 0;
   int rx_left = 0;
   int stall_cycles = 0;
   logic long_stall_done = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (!long_stall_done && responses_seen >= 400) begin
            long_stall_done = 1'b1;
            stall_cycles = 300;
         end
         if (stall_cycles > 0) begin
            stall_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            if (rx_left == 0) begin
               rx_mode = $urandom_range(0, 2);
               rx_left = (rx_mode == 2) ? $urandom_range(1, 8) : $urandom_range(1, 40);
            end
            rx_left--;
            case (rx_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= 1'b0;
            endcase
         end
      end
   end

   task automatic push_poll(input logic level, input logic tick);
      pin_poll_type p;
      p.level = level;
      p.tick = tick;
      pending_polls.push_back(p);
      polls_queued++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (responses_seen < polls_queued || pending_polls.size() != 0 || req_tvalid);
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_timing(input int deb, input int lng);
      wait_idle();
      csr_write(CSR_DEBOUNCE_TICKS, CSR_DATA_WIDTH'(deb));
      csr_write(CSR_LONG_PRESS_TICKS, CSR_DATA_WIDTH'(lng));
   endtask

   task automatic add_noise();
      int n;
      n = $urandom_range(1, 20);
      repeat (n) push_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // A bouncy press, a hold, a bouncy release and a quiet stretch.
   task automatic add_press(input int deb, input int lng);
      int hold;
      int quiet;
      repeat ($urandom_range(0, 5))
         push_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 4) == 0) hold = $urandom_range(0, deb);
      else hold = deb + deb / 4 + 2 + $urandom_range(0, 2 * lng + 8);
      repeat (hold) push_poll(1'b0, $urandom_range(0, 7) != 0);
      repeat ($urandom_range(0, 5))
         push_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      quiet = deb + deb / 4 + 2 + $urandom_range(0, 6);
      repeat (quiet) push_poll(1'b1, $urandom_range(0, 7) != 0);
   endtask

   task automatic run_phase(input int deb, input int lng, input int budget);
      int start;
      set_timing(deb, lng);
      start = polls_queued;
      while (polls_queued - start < budget) begin
         if ($urandom_range(0, 9) == 0) add_noise();
         else add_press(deb, lng);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings, then writes to unused indexes that must change nothing.
      push_poll(1'b1, 1'b1);
      push_poll(1'b0, 1'b1);
      push_poll(1'b1, 1'b0);
      push_poll(1'b0, 1'b0);
      wait_idle();
      csr_write(CSR_SPARE_LOW, '0);
      csr_write(CSR_SPARE_HIGH, '1);

      // Zero debounce and zero long press: adopted and long on the same poll.
      set_timing(0, 0);
      push_poll(1'b1, 1'b1);
      push_poll(1'b0, 1'b1);
      push_poll(1'b0, 1'b1);
      push_poll(1'b1, 1'b1);
      push_poll(1'b1, 1'b0);

      // Long after two held ticks, then a release after long, then a short press.
      set_timing(0, 2);
      push_poll(1'b0, 1'b0);
      push_poll(1'b0, 1'b1);
      push_poll(1'b0, 1'b1);
      push_poll(1'b0, 1'b1);
      push_poll(1'b1, 1'b0);
      push_poll(1'b0, 1'b1);
      push_poll(1'b1, 1'b1);

      // A tick on a changing poll is not counted; a bounce restarts the age.
      set_timing(2, 5);
      push_poll(1'b0, 1'b1);
      push_poll(1'b0, 1'b1);
      push_poll(1'b1, 1'b1);
      push_poll(1'b0, 1'b0);
      push_poll(1'b0, 1'b1);
      push_poll(1'b0, 1'b1);
      push_poll(1'b0, 1'b1);
      push_poll(1'b1, 1'b1);
      push_poll(1'b1, 1'b1);
      push_poll(1'b1, 1'b1);

      run_phase(DEBOUNCE_RESET, LONG_PRESS_RESET, 500);
      run_phase(0, 0, 150);
      run_phase(1, 5, 150);
      run_phase(3, 20, 200);
      run_phase(7, 1, 150);
      run_phase(255, 3, 1);
      run_phase(2, 12, 150);
      run_phase(4, 30, 150);

      wait_idle();
      repeat (10) @(posedge clock);
      if (err_count == 0) $display("testbench: done, clean");
      else $display("testbench: done, errors");
      $finish;
   end

endmodule
